[rtl/core/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[rtl/core/encspd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package encspd_pkg;

  // default field widths
  localparam int POSITION_BITS_DEF = 12;
  localparam int CAPTURE_BITS_DEF  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENCODER_COUNTS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_PP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN_NEW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN_OLD  = 3'd5;

  // register widths
  localparam int ENC_COUNTS_W = 13;
  localparam int MOTOR_PP_W   = 5;
  localparam int ANGLE_W      = 16;
  localparam int DEC_LIMIT_W  = 16;
  localparam int GAIN_W       = 15;

  // register reset values
  localparam logic [ENC_COUNTS_W-1:0] ENC_COUNTS_RST = 13'd4000;
  localparam logic [MOTOR_PP_W-1:0]   MOTOR_PP_RST   = 5'd2;
  localparam logic [ANGLE_W-1:0]      ANGLE_OFS_RST  = 16'd24940;
  localparam logic [DEC_LIMIT_W-1:0]  DEC_LIMIT_RST  = 16'd9;
  localparam logic [GAIN_W-1:0]       GAIN_NEW_RST   = 15'd3277;
  localparam logic [GAIN_W-1:0]       GAIN_OLD_RST   = 15'd29491;

  // speed arithmetic
  localparam int SPEED_W      = 25;
  localparam int S25_MAX      = 16777215;
  localparam int S25_MIN      = -16777216;
  localparam int RPM_PER_CNT  = 15;
  localparam int WE_GAIN_Q20  = 219609;   // 0.20944 in q20
  localparam int WE_GAIN_W    = 18;
  localparam int WE_SHIFT     = 20;
  localparam int WRAP_HI_CNT  = 500;
  localparam int WRAP_LO_CNT  = -3500;
  localparam int POS_TOTAL_W  = 27;       // integer plus fraction bits of a position

  // result packing: angle, dir, update, speed, electrical speed
  localparam int OUT_FIELDS_W = ANGLE_W + 2 + 2 * SPEED_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

[rtl/core/encoder_angle_speed_estimator.sv]
// Encoder angle and speed estimator.
// s_axis carries one transaction per control tick: the latched position count,
// direction and capture timer/period. m_axis returns one transaction per tick
// with the electrical angle, the direction copy, the speed update flag, the
// filtered mechanical speed and the electrical speed. The cfg channel writes
// the six registers by index and is always ready; write it only while idle.
// One shift/add unit does all the work under a small sequencer, so the block
// takes one tick at a time and drops s_axis_tready while busy.
// Angle: restoring division of count*pp*2^16 by encoder_counts, one
// quotient bit per cycle, between the accept and the handoff steps.
// Speed ticks add the timer/period division (skipped when the period is
// zero or the timer has run out), three serial multiplies and five further
// steps: new position, difference, wrap correction and the two saturations.
// The result sits in an output register: if m_axis stalls, the next tick is
// still accepted and worked on, and it waits in its last state until the
// register frees up. Reset restores the register defaults and clears the tick
// counter, the stored position and the filter state.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module encoder_angle_speed_estimator #(
  parameter int POSITION_BITS = encspd_pkg::POSITION_BITS_DEF,
  parameter int CAPTURE_BITS  = encspd_pkg::CAPTURE_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // config write channel
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [encspd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [encspd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // tick input stream
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // low to high: position_count, direction, capture_timer, capture_period
  input  wire logic [((POSITION_BITS+1+2*CAPTURE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // result stream
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // low to high: elec_angle, dir_copy, speed_update, speed_filtered,
  // speed_electrical
  output logic [encspd_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

  localparam int FRAC_BITS = encspd_pkg::POS_TOTAL_W - POSITION_BITS;
  localparam int NW  = POSITION_BITS + encspd_pkg::MOTOR_PP_W + encspd_pkg::ANGLE_W;
  localparam int CW  = $clog2(NW + 1);
  localparam int PW  = encspd_pkg::POS_TOTAL_W + 1;
  localparam int NPW = encspd_pkg::ENC_COUNTS_W + FRAC_BITS;
  localparam int DW  = ((NPW > PW) ? NPW : PW) + 2;
  localparam int MW  = encspd_pkg::GAIN_W + 4;
  localparam int AW0 = ((MW + DW) > (FRAC_BITS + 32)) ? (MW + DW) : (FRAC_BITS + 32);
  localparam int AW  = AW0 + 1;
  localparam int SW  = encspd_pkg::SPEED_W;
  localparam int EW  = encspd_pkg::ENC_COUNTS_W;
  localparam int RAW = encspd_pkg::ENC_COUNTS_W + 1;
  localparam int QW  = encspd_pkg::ANGLE_W;
  localparam int PROD_W = POSITION_BITS + encspd_pkg::MOTOR_PP_W;

  localparam logic signed [DW-1:0] WRAP_HI =
    DW'(encspd_pkg::WRAP_HI_CNT * (1 << FRAC_BITS));
  localparam logic signed [DW-1:0] WRAP_LO =
    DW'(encspd_pkg::WRAP_LO_CNT * (1 << FRAC_BITS));
  localparam logic signed [AW-1:0] SAT_MAX = AW'(encspd_pkg::S25_MAX);
  localparam logic signed [AW-1:0] SAT_MIN = AW'(encspd_pkg::S25_MIN);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ADIV = 4'd1;
  localparam logic [3:0] ST_FDIV = 4'd2;
  localparam logic [3:0] ST_NPOS = 4'd3;
  localparam logic [3:0] ST_DIFF = 4'd4;
  localparam logic [3:0] ST_CORR = 4'd5;
  localparam logic [3:0] ST_MUL1 = 4'd6;
  localparam logic [3:0] ST_MUL2 = 4'd7;
  localparam logic [3:0] ST_FSAT = 4'd8;
  localparam logic [3:0] ST_MUL3 = 4'd9;
  localparam logic [3:0] ST_WSAT = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  function automatic logic signed [SW-1:0] sat25(input logic signed [AW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_MAX) begin
      r = SW'(encspd_pkg::S25_MAX);
    end else if (v < SAT_MIN) begin
      r = SW'(encspd_pkg::S25_MIN);
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [EW-1:0]                         enc_counts_q;
  logic [encspd_pkg::MOTOR_PP_W-1:0]     motor_pp_q;
  logic [encspd_pkg::ANGLE_W-1:0]        angle_ofs_q;
  logic [encspd_pkg::DEC_LIMIT_W-1:0]    dec_limit_q;
  logic [encspd_pkg::GAIN_W-1:0]         gain_new_q;
  logic [encspd_pkg::GAIN_W-1:0]         gain_old_q;

  // control and persistent state
  logic [3:0]                            state_q, state_d;
  logic [CW-1:0]                         cnt_q, cnt_d;
  logic [encspd_pkg::DEC_LIMIT_W-1:0]    tick_q, tick_d;
  logic                                  upd_q, upd_d;
  logic [PW-1:0]                         prev_q, prev_d;
  logic signed [SW-1:0]                  fs_q, fs_d;
  logic signed [SW-1:0]                  we_q, we_d;
  logic                                  m_valid_q, m_valid_d;

  // working registers
  logic [POSITION_BITS-1:0]              count_q, count_d;
  logic                                  dir_q, dir_d;
  logic [CAPTURE_BITS-1:0]               timer_q, timer_d;
  logic [CAPTURE_BITS-1:0]               period_q, period_d;
  logic [NW-1:0]                         num_q, num_d;
  logic [EW-1:0]                         rema_q, rema_d;
  logic [QW-1:0]                         quo_q, quo_d;
  logic [CAPTURE_BITS-1:0]               remf_q, remf_d;
  logic [FRAC_BITS:0]                    frac_q, frac_d;
  logic [PW-1:0]                         newpos_q, newpos_d;
  logic signed [DW-1:0]                  diff_q, diff_d;
  logic signed [AW-1:0]                  acc_q, acc_d;
  logic signed [AW-1:0]                  mcand_q, mcand_d;
  logic [MW-1:0]                         mult_q, mult_d;
  logic [encspd_pkg::OUT_DATA_W-1:0]     m_data_q, m_data_d;

  // shared adder
  logic [AW-1:0]                         opa, opb, sum;
  logic                                  cin;
  logic                                  ge;

  logic                                  s_fire;
  logic [RAW-1:0]                        r2a;
  logic [CAPTURE_BITS:0]                 r2f;
  logic [AW-1:0]                         nshift;
  logic                                  wrap_hi, wrap_lo;
  logic [PROD_W-1:0]                     prod;
  logic [QW-1:0]                         mech;
  logic [QW-1:0]                         angle;
  logic                                  last;
  logic signed [SW-1:0]                  fs_new;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign r2a     = {rema_q, num_q[NW-1]};
  assign r2f     = {remf_q, 1'b0};
  assign nshift  = AW'(enc_counts_q) << FRAC_BITS;
  assign wrap_hi = diff_q > WRAP_HI;
  assign wrap_lo = diff_q < WRAP_LO;
  assign prod    = PROD_W'(s_axis_tdata[POSITION_BITS-1:0]) * PROD_W'(motor_pp_q);
  assign mech    = (enc_counts_q == '0) ? '0 : quo_q;
  assign angle   = mech + angle_ofs_q;
  assign last    = (cnt_q == '0);
  assign fs_new  = sat25(acc_q >>> (FRAC_BITS + 7));

  // operand selection for the shared adder
  always_comb begin
    opa = '0;
    opb = '0;
    cin = 1'b0;
    case (state_q)
      ST_ADIV: begin
        opa = AW'(r2a);
        opb = ~AW'(enc_counts_q);
        cin = 1'b1;
      end
      ST_FDIV: begin
        opa = AW'(r2f);
        opb = ~AW'(period_q);
        cin = 1'b1;
      end
      ST_NPOS: begin
        opa = AW'(count_q) << FRAC_BITS;
        opb = AW'(frac_q);
      end
      ST_DIFF: begin
        opa = AW'(newpos_q);
        opb = ~AW'(prev_q);
        cin = 1'b1;
      end
      ST_CORR: begin
        opa = AW'(diff_q);
        opb = wrap_hi ? ~nshift : nshift;
        cin = wrap_hi;
      end
      ST_MUL1, ST_MUL2, ST_MUL3: begin
        opa = acc_q;
        opb = mult_q[0] ? mcand_q : '0;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign sum = opa + opb + AW'(cin);
  assign ge  = !sum[AW-1];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    tick_d    = tick_q;
    upd_d     = upd_q;
    prev_d    = prev_q;
    fs_d      = fs_q;
    we_d      = we_q;
    count_d   = count_q;
    dir_d     = dir_q;
    timer_d   = timer_q;
    period_d  = period_q;
    num_d     = num_q;
    rema_d    = rema_q;
    quo_d     = quo_q;
    remf_d    = remf_q;
    frac_d    = frac_q;
    newpos_d  = newpos_q;
    diff_d    = diff_q;
    acc_d     = acc_q;
    mcand_d   = mcand_q;
    mult_d    = mult_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          count_d  = s_axis_tdata[POSITION_BITS-1:0];
          dir_d    = s_axis_tdata[POSITION_BITS];
          timer_d  = s_axis_tdata[POSITION_BITS+1 +: CAPTURE_BITS];
          period_d = s_axis_tdata[POSITION_BITS+1+CAPTURE_BITS +: CAPTURE_BITS];
          num_d    = {prod, {encspd_pkg::ANGLE_W{1'b0}}};
          rema_d   = '0;
          quo_d    = '0;
          cnt_d    = CW'(NW - 1);
          if (tick_q < dec_limit_q) begin
            tick_d = tick_q + 1'b1;
            upd_d  = 1'b0;
          end else begin
            tick_d = '0;
            upd_d  = 1'b1;
          end
          state_d = ST_ADIV;
        end
      end
      ST_ADIV: begin
        rema_d = ge ? sum[EW-1:0] : r2a[EW-1:0];
        quo_d  = {quo_q[QW-2:0], ge};
        num_d  = num_q << 1;
        cnt_d  = cnt_q - 1'b1;
        if (last) begin
          frac_d = '0;
          if (!upd_q) begin
            state_d = ST_DONE;
          end else if (period_q == '0) begin
            state_d = ST_NPOS;
          end else if (timer_q >= period_q) begin
            // timer ran out: a full count
            frac_d  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
            state_d = ST_NPOS;
          end else begin
            remf_d  = timer_q;
            cnt_d   = CW'(FRAC_BITS - 1);
            state_d = ST_FDIV;
          end
        end
      end
      ST_FDIV: begin
        remf_d = ge ? sum[CAPTURE_BITS-1:0] : r2f[CAPTURE_BITS-1:0];
        frac_d = {frac_q[FRAC_BITS-1:0], ge};
        cnt_d  = cnt_q - 1'b1;
        if (last) begin
          state_d = ST_NPOS;
        end
      end
      ST_NPOS: begin
        newpos_d = sum[PW-1:0];
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        diff_d  = sum[DW-1:0];
        prev_d  = newpos_q;
        state_d = ST_CORR;
      end
      ST_CORR: begin
        // unwrap across the turn boundary
        if (wrap_hi || wrap_lo) begin
          diff_d = sum[DW-1:0];
        end
        mcand_d = AW'(diff_d);
        mult_d  = (MW'(gain_new_q) << 4) - MW'(gain_new_q);
        acc_d   = AW'(1) <<< (FRAC_BITS + 6);
        cnt_d   = CW'(MW - 1);
        state_d = ST_MUL1;
      end
      ST_MUL1, ST_MUL2, ST_MUL3: begin
        acc_d   = sum;
        mcand_d = mcand_q <<< 1;
        mult_d  = mult_q >> 1;
        cnt_d   = cnt_q - 1'b1;
        if (last) begin
          case (state_q)
            ST_MUL1: begin
              mcand_d = AW'(fs_q) <<< (FRAC_BITS - 8);
              mult_d  = MW'(gain_old_q);
              cnt_d   = CW'(encspd_pkg::GAIN_W - 1);
              state_d = ST_MUL2;
            end
            ST_MUL2: begin
              state_d = ST_FSAT;
            end
            default: begin
              state_d = ST_WSAT;
            end
          endcase
        end
      end
      ST_FSAT: begin
        fs_d    = fs_new;
        mcand_d = AW'(fs_new);
        mult_d  = MW'(encspd_pkg::WE_GAIN_Q20);
        acc_d   = AW'(1) <<< (encspd_pkg::WE_SHIFT - 1);
        cnt_d   = CW'(encspd_pkg::WE_GAIN_W - 1);
        state_d = ST_MUL3;
      end
      ST_WSAT: begin
        we_d    = sat25(acc_q >>> encspd_pkg::WE_SHIFT);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = encspd_pkg::OUT_DATA_W'({we_q, fs_q, upd_q, dir_q, angle});
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_counts_q <= encspd_pkg::ENC_COUNTS_RST;
      motor_pp_q   <= encspd_pkg::MOTOR_PP_RST;
      angle_ofs_q  <= encspd_pkg::ANGLE_OFS_RST;
      dec_limit_q  <= encspd_pkg::DEC_LIMIT_RST;
      gain_new_q   <= encspd_pkg::GAIN_NEW_RST;
      gain_old_q   <= encspd_pkg::GAIN_OLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        encspd_pkg::REG_ENCODER_COUNTS:   enc_counts_q <= cfg_data_i[EW-1:0];
        encspd_pkg::REG_MOTOR_PP:
          motor_pp_q <= cfg_data_i[encspd_pkg::MOTOR_PP_W-1:0];
        encspd_pkg::REG_ANGLE_OFFSET:     angle_ofs_q  <= cfg_data_i;
        encspd_pkg::REG_DECIMATION_LIMIT: dec_limit_q  <= cfg_data_i;
        encspd_pkg::REG_FILTER_GAIN_NEW:
          gain_new_q <= cfg_data_i[encspd_pkg::GAIN_W-1:0];
        encspd_pkg::REG_FILTER_GAIN_OLD:
          gain_old_q <= cfg_data_i[encspd_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      tick_q    <= '0;
      upd_q     <= 1'b0;
      prev_q    <= '0;
      fs_q      <= '0;
      we_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      tick_q    <= tick_d;
      upd_q     <= upd_d;
      prev_q    <= prev_d;
      fs_q      <= fs_d;
      we_q      <= we_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    dir_q    <= dir_d;
    timer_q  <= timer_d;
    period_q <= period_d;
    num_q    <= num_d;
    rema_q   <= rema_d;
    quo_q    <= quo_d;
    remf_q   <= remf_d;
    frac_q   <= frac_d;
    newpos_q <= newpos_d;
    diff_q   <= diff_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mult_q   <= mult_d;
    m_data_q <= m_data_d;
  end

  `ASSERT_PROP(a_accept_starts_div, clk_i, rst_ni,
    (s_fire |=> state_q == ST_ADIV), "accepted tick did not start the angle division")

  `ASSERT_NEVER(a_speed_only_on_update, clk_i, rst_ni,
    ((state_q == ST_FDIV || state_q == ST_NPOS || state_q == ST_MUL1) && !upd_q),
    "speed path entered on a tick without update")

  `ASSERT_NEVER(a_div_count_bound, clk_i, rst_ni,
    (state_q == ST_ADIV && cnt_q >= CW'(NW)), "angle division ran past its bit count")

  `ASSERT_PROP(a_done_frees_output, clk_i, rst_ni,
    ((state_q == ST_DONE && (!m_valid_q || m_axis_tready)) |=> m_valid_q && state_q == ST_IDLE),
    "finished tick was not handed to the output register")

endmodule

`default_nettype wire
